// ===== design/polyline_douglas_peucker_macros.svh =====
// Assertion macros shared by the checker of the polyline simplifier.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef POLYLINE_DOUGLAS_PEUCKER_MACROS_SVH
`define POLYLINE_DOUGLAS_PEUCKER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PDP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pdp_pkg.sv =====
// Package of the polyline simplifier: widths, defaults, codes and shared types.
// Depends on nothing; used by pdp_mul, the top level and the testbench.
package pdp_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 24;

    localparam int TOL_W       = 23;
    localparam int SPACING_W   = 7;
    localparam int KIDX_W      = 6;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_INDEX_W = 1;

    localparam logic [TOL_W-1:0] TOL_RESET = 23'd256;

    localparam int WORD_W    = 64;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int CHUNK_W   = 16;
    localparam int MUL_STEPS = WORD_W / CHUNK_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOLERANCE,
        REG_MAX_SPACING
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_TOL2,
        S_POP,
        S_POPW,
        S_RDB,
        S_GETB,
        S_NSQ1,
        S_NSQ2,
        S_SCAN_RD,
        S_SCAN_D,
        S_M1,
        S_M2,
        S_DECIDE,
        S_W2,
        S_TN,
        S_KEEP,
        S_PUSH2,
        S_FORCE,
        S_EMIT,
        S_EMIT_END
    } pdp_state_t;

    typedef struct packed {
        logic              go;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

endpackage

// ===== design/pdp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module pdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/pdp_mul.sv =====
// Shared multi-cycle multiplier: 64 by 64 bits to a 128-bit product, one
// 16-bit digit of b per cycle. Depends on pdp_pkg.
module pdp_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pdp_pkg::mul_req_t         req,
    output logic                      done,
    output logic [pdp_pkg::PROD_W-1:0] product
);
    import pdp_pkg::*;

    logic [WORD_W-1:0]         a_reg;
    logic [WORD_W-1:0]         b_reg, b_next;
    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [WORD_W+CHUNK_W-1:0] partial;

    // Most significant digit first, so the accumulator shifts left each step.
    assign partial = a_reg * b_reg[WORD_W-1 -: CHUNK_W];

    always_comb
    begin
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            b_next    = req.b;
            acc_next  = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next  = {acc_reg[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                        + PROD_W'(partial);
            b_next    = {b_reg[WORD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(MUL_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            a_reg <= req.a;
        end
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// ===== design/polyline_douglas_peucker.sv =====
// Top level of the Douglas-Peucker polyline simplifier with forced keeps.
// Depends on pdp_pkg, pdp_ram (point store, range stack) and pdp_mul.
//
// Usage. Points are offered on pos_x, pos_y and is_last with start; a
// transaction is taken at a rising edge where start is high and busy low.
// Points without is_last keep busy low, so a polyline loads at one point per
// cycle. Points past MAX_POINTS are dropped. The transaction carrying
// is_last raises busy and the tolerance is squared; each product of the
// shared multiplier holds the sequencer for an issue, four 16-bit digit
// steps and a result. A range pops, reads its ends and squares its chord,
// inner points are read, differenced and multiplied, and the farthest is
// squared and compared (compared only if the chord collapses). A kept split
// pushes both halves; a short range is only popped. Forced keeps mark every
// index divisible by the maximum spacing. Kept points leave in index order
// as the scan passes every stored point, each as a one-cycle result_strobe
// with kept_x, kept_y, kept_index; end_of_run marks the last, and busy falls
// the cycle after it. Results cannot be stalled, so none are ever held.
// Reset clears the stored count, keep flags, stack and sequencer and loads
// the configuration registers with their reset values; configuration writes
// on cfg_we take effect at once and are meant to be made while busy is low.
module polyline_douglas_peucker #(
    parameter int MAX_POINTS = pdp_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = pdp_pkg::DEF_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pdp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pdp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      pos_x,
    input  logic signed [COORD_BITS-1:0]      pos_y,
    input  logic                              is_last,
    output logic                              result_strobe,
    output logic signed [COORD_BITS-1:0]      kept_x,
    output logic signed [COORD_BITS-1:0]      kept_y,
    output logic [pdp_pkg::KIDX_W-1:0]        kept_index,
    output logic                              end_of_run
);
    import pdp_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = ((CNT_W > SPACING_W) ? CNT_W : SPACING_W) + 1;
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int STK_W = 2 * IDX_W;

    function automatic logic [WORD_W-1:0] sext(input logic [COORD_BITS-1:0] v);
        return {{(WORD_W-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // Top of the stack sits one below the current depth.
    function automatic logic [IDX_W-1:0] n_minus_depth(input logic [CNT_W-1:0] d);
        logic [CNT_W-1:0] t;
        t = d - 1'b1;
        return t[IDX_W-1:0];
    endfunction

    // Sequencer and configuration state.
    pdp_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOL_W-1:0]      tol_reg, tol_next;
    logic [SPACING_W-1:0]  spacing_reg, spacing_next;
    logic [MAX_POINTS-1:0] keep_reg, keep_next;
    logic                  keep_all_reg, keep_all_next;
    logic [CNT_W-1:0]      depth_reg, depth_next;
    logic                  issued_reg, issued_next;
    logic                  pend_v_reg, pend_v_next;

    // Datapath registers.
    logic [IDX_W-1:0]      lo_reg, lo_next, hi_reg, hi_next, wk_reg, wk_next;
    logic [IDX_W-1:0]      k_reg, k_next, pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic                  pend_last_reg, pend_last_next;
    logic [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [WORD_W-1:0]     abx_reg, abx_next, aby_reg, aby_next;
    logic [WORD_W-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic [WORD_W-1:0]     nsq_reg, nsq_next, tol2_reg, tol2_next;
    logic [WORD_W-1:0]     tmp_reg, tmp_next, worst_reg, worst_next;
    logic [PROD_W-1:0]     big_reg, big_next;

    // Memories and the shared multiplier.
    logic                  pt_we;
    logic [IDX_W-1:0]      pt_raddr;
    logic [PT_W-1:0]       pt_rdata;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr, stk_raddr;
    logic [STK_W-1:0]      stk_wdata, stk_rdata;
    mul_req_t              mul_req;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_prod;

    // Shared conditions.
    logic                  accept;
    logic                  mul_state;
    logic [CNT_W-1:0]      n_minus1;
    logic [COORD_BITS-1:0] px, py;
    logic [IDX_W-1:0]      pop_lo, pop_hi;
    logic                  pop_splits;
    logic                  nsq_zero;
    logic                  more_k;
    logic [WORD_W-1:0]     m_sum, m_diff, metric;
    logic                  metric_wins;
    logic [SUM_W-1:0]      force_sum;
    logic                  stk_room;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign n_minus1  = count_reg - 1'b1;
    assign px        = pt_rdata[PT_W-1:COORD_BITS];
    assign py        = pt_rdata[COORD_BITS-1:0];
    assign pop_lo    = stk_rdata[STK_W-1:IDX_W];
    assign pop_hi    = stk_rdata[IDX_W-1:0];
    assign pop_splits = {1'b0, pop_hi} > ({1'b0, pop_lo} + 1'b1);
    assign nsq_zero  = (nsq_reg == '0);
    assign more_k    = ({1'b0, k_reg} + 1'b1) < {1'b0, hi_reg};
    assign m_sum     = tmp_reg + mul_prod[WORD_W-1:0];
    assign m_diff    = tmp_reg - mul_prod[WORD_W-1:0];
    assign metric    = nsq_zero ? m_sum : (m_diff[WORD_W-1] ? (-m_diff) : m_diff);
    assign metric_wins = (k_reg == lo_reg + 1'b1) || (metric > worst_reg);
    assign force_sum = SUM_W'(i_reg) + SUM_W'(spacing_reg);
    assign stk_room  = depth_reg < CNT_W'(MAX_POINTS);
    assign mul_state = (state_reg == S_TOL2) || (state_reg == S_NSQ1)
                    || (state_reg == S_NSQ2) || (state_reg == S_M1)
                    || (state_reg == S_M2) || (state_reg == S_W2)
                    || (state_reg == S_TN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (count_reg < CNT_W'(3) || tol_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_TOL2;
                end
            end
            S_TOL2:
            begin
                if (mul_done)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (depth_reg != '0)
                begin
                    state_next = S_POPW;
                end
                else if (spacing_reg != '0)
                begin
                    state_next = S_FORCE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_POPW:     state_next = pop_splits ? S_RDB : S_POP;
            S_RDB:      state_next = S_GETB;
            S_GETB:     state_next = S_NSQ1;
            S_NSQ1:
            begin
                if (mul_done)
                begin
                    state_next = S_NSQ2;
                end
            end
            S_NSQ2:
            begin
                if (mul_done)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  state_next = S_SCAN_D;
            S_SCAN_D:   state_next = S_M1;
            S_M1:
            begin
                if (mul_done)
                begin
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                if (mul_done)
                begin
                    state_next = more_k ? S_SCAN_RD : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!nsq_zero)
                begin
                    state_next = S_W2;
                end
                else
                begin
                    state_next = (worst_reg > tol2_reg) ? S_KEEP : S_POP;
                end
            end
            S_W2:
            begin
                if (mul_done)
                begin
                    state_next = S_TN;
                end
            end
            S_TN:
            begin
                if (mul_done)
                begin
                    state_next = (big_reg > mul_prod) ? S_KEEP : S_POP;
                end
            end
            S_KEEP:     state_next = S_PUSH2;
            S_PUSH2:    state_next = S_POP;
            S_FORCE:
            begin
                if (force_sum >= SUM_W'(count_reg))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (i_reg == n_minus1)
                begin
                    state_next = S_EMIT_END;
                end
            end
            S_EMIT_END: state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, memory and multiplier controls.
    always_comb
    begin
        count_next     = count_reg;
        tol_next       = tol_reg;
        spacing_next   = spacing_reg;
        keep_next      = keep_reg;
        keep_all_next  = keep_all_reg;
        depth_next     = depth_reg;
        pend_v_next    = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        wk_next        = wk_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        abx_next       = abx_reg;
        aby_next       = aby_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        nsq_next       = nsq_reg;
        tol2_next      = tol2_reg;
        tmp_next       = tmp_reg;
        worst_next     = worst_reg;
        big_next       = big_reg;
        pt_we          = 1'b0;
        pt_raddr       = '0;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[IDX_W-1:0];
        stk_wdata      = {lo_reg, wk_reg};
        stk_raddr      = '0;
        mul_req.go     = mul_state && !issued_reg;
        mul_req.a      = '0;
        mul_req.b      = '0;
        issued_next    = issued_reg;

        if (mul_done)
        begin
            issued_next = 1'b0;
        end
        else if (mul_req.go)
        begin
            issued_next = 1'b1;
        end

        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TOLERANCE:   tol_next     = cfg_data[TOL_W-1:0];
                REG_MAX_SPACING: spacing_next = cfg_data[SPACING_W-1:0];
                default:         tol_next     = tol_reg;
            endcase
        end

        if (accept && count_reg < CNT_W'(MAX_POINTS))
        begin
            pt_we      = 1'b1;
            count_next = count_reg + 1'b1;
        end

        unique case (state_reg)
            S_INIT:
            begin
                i_next = '0;
                if (count_reg < CNT_W'(3) || tol_reg == '0)
                begin
                    keep_all_next = 1'b1;
                end
                else
                begin
                    keep_next[0]                   = 1'b1;
                    keep_next[n_minus1[IDX_W-1:0]] = 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {{IDX_W{1'b0}}, n_minus1[IDX_W-1:0]};
                    depth_next = CNT_W'(1);
                end
            end
            S_TOL2:
            begin
                mul_req.a = WORD_W'(tol_reg);
                mul_req.b = WORD_W'(tol_reg);
                if (mul_done)
                begin
                    tol2_next = mul_prod[WORD_W-1:0];
                end
            end
            S_POP:
            begin
                i_next = '0;
                if (depth_reg != '0)
                begin
                    stk_raddr  = n_minus_depth(depth_reg);
                    depth_next = depth_reg - 1'b1;
                end
            end
            S_POPW:
            begin
                lo_next  = pop_lo;
                hi_next  = pop_hi;
                pt_raddr = pop_lo;
            end
            S_RDB:
            begin
                pt_raddr = hi_reg;
                ax_next  = px;
                ay_next  = py;
            end
            S_GETB:
            begin
                abx_next = sext(px) - sext(ax_reg);
                aby_next = sext(py) - sext(ay_reg);
            end
            S_NSQ1:
            begin
                mul_req.a = abx_reg;
                mul_req.b = abx_reg;
                if (mul_done)
                begin
                    tmp_next = mul_prod[WORD_W-1:0];
                end
            end
            S_NSQ2:
            begin
                mul_req.a = aby_reg;
                mul_req.b = aby_reg;
                if (mul_done)
                begin
                    nsq_next   = m_sum;
                    k_next     = lo_reg + 1'b1;
                    worst_next = '0;
                end
            end
            S_SCAN_RD:
            begin
                pt_raddr = k_reg;
            end
            S_SCAN_D:
            begin
                dx_next = sext(ax_reg) - sext(px);
                dy_next = sext(ay_reg) - sext(py);
            end
            S_M1:
            begin
                mul_req.a = nsq_zero ? dx_reg : abx_reg;
                mul_req.b = nsq_zero ? dx_reg : dy_reg;
                if (mul_done)
                begin
                    tmp_next = mul_prod[WORD_W-1:0];
                end
            end
            S_M2:
            begin
                mul_req.a = nsq_zero ? dy_reg : dx_reg;
                mul_req.b = nsq_zero ? dy_reg : aby_reg;
                if (mul_done)
                begin
                    if (metric_wins)
                    begin
                        worst_next = metric;
                        wk_next    = k_reg;
                    end
                    k_next = k_reg + 1'b1;
                end
            end
            S_W2:
            begin
                mul_req.a = worst_reg;
                mul_req.b = worst_reg;
                if (mul_done)
                begin
                    big_next = mul_prod;
                end
            end
            S_TN:
            begin
                mul_req.a = tol2_reg;
                mul_req.b = nsq_reg;
            end
            S_KEEP:
            begin
                keep_next[wk_reg] = 1'b1;
                stk_wdata         = {lo_reg, wk_reg};
                if (stk_room)
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            S_PUSH2:
            begin
                stk_wdata = {wk_reg, hi_reg};
                if (stk_room)
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            S_FORCE:
            begin
                keep_next[i_reg[IDX_W-1:0]] = 1'b1;
                if (force_sum >= SUM_W'(count_reg))
                begin
                    i_next = '0;
                end
                else
                begin
                    i_next = force_sum[CNT_W-1:0];
                end
            end
            S_EMIT:
            begin
                pt_raddr       = i_reg[IDX_W-1:0];
                pend_v_next    = keep_all_reg || keep_reg[i_reg[IDX_W-1:0]];
                pend_idx_next  = i_reg[IDX_W-1:0];
                pend_last_next = (i_reg == n_minus1);
                i_next         = i_reg + 1'b1;
            end
            S_EMIT_END:
            begin
                keep_next     = '0;
                keep_all_next = 1'b0;
                count_next    = '0;
                depth_next    = '0;
            end
            default:
            begin
                pt_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            tol_reg      <= TOL_RESET;
            spacing_reg  <= '0;
            keep_reg     <= '0;
            keep_all_reg <= 1'b0;
            depth_reg    <= '0;
            issued_reg   <= 1'b0;
            pend_v_reg   <= 1'b0;
            i_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            tol_reg      <= tol_next;
            spacing_reg  <= spacing_next;
            keep_reg     <= keep_next;
            keep_all_reg <= keep_all_next;
            depth_reg    <= depth_next;
            issued_reg   <= issued_next;
            pend_v_reg   <= pend_v_next;
            i_reg        <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        wk_reg        <= wk_next;
        k_reg         <= k_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        abx_reg       <= abx_next;
        aby_reg       <= aby_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        nsq_reg       <= nsq_next;
        tol2_reg      <= tol2_next;
        tmp_reg       <= tmp_next;
        worst_reg     <= worst_next;
        big_reg       <= big_next;
    end

    // Point store: x in the upper half, y in the lower half.
    pdp_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .clk   (clk),
        .we    (pt_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({pos_x, pos_y}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // Range stack: start index in the upper half, end index in the lower.
    pdp_ram #(
        .WIDTH (STK_W),
        .DEPTH (MAX_POINTS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    pdp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Results come straight from the point store read port, qualified by the
    // registered scan flags.
    assign result_strobe = pend_v_reg;
    assign kept_x        = px;
    assign kept_y        = py;
    assign kept_index    = KIDX_W'(pend_idx_reg);
    assign end_of_run    = pend_v_reg && pend_last_reg;
endmodule

// ===== design/pdp_checker.sv =====
// Port-level checker of the polyline simplifier and its bind statement.
// Depends on polyline_douglas_peucker_macros.svh.
`include "polyline_douglas_peucker_macros.svh"

module pdp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic is_last,
    input logic busy,
    input logic result_strobe,
    input logic end_of_run
);
    `PDP_ASSERT_IMP(a_strobe_busy, result_strobe, busy, "result outside a run")
    `PDP_ASSERT_IMP(a_eor_strobe, end_of_run, result_strobe, "end_of_run without result")
    `PDP_ASSERT_NXT(a_eor_idle, result_strobe && end_of_run, !busy, "run did not end")
    `PDP_ASSERT_IMP(a_busy_rise, $rose(busy), $past(start && is_last), "run without last point")
endmodule

bind polyline_douglas_peucker pdp_checker u_pdp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .is_last       (is_last),
    .busy          (busy),
    .result_strobe (result_strobe),
    .end_of_run    (end_of_run)
);

// ===== tb/polyline_douglas_peucker_tb.sv =====
// Self-checking testbench for the Douglas-Peucker polyline simplifier.
// Depends on pdp_pkg and polyline_douglas_peucker; it reads no file.
`timescale 1ns / 1ps

module polyline_douglas_peucker_tb;
    import pdp_pkg::*;

    localparam int NPTS = 64;
    localparam int CB = 24;
    localparam int IDLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } point_t;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic [KIDX_W-1:0]    idx;
        logic                 eor;
    } kept_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [CB-1:0] pos_x = '0;
    logic signed [CB-1:0] pos_y = '0;
    logic is_last = 1'b0;
    logic result_strobe;
    logic signed [CB-1:0] kept_x;
    logic signed [CB-1:0] kept_y;
    logic [KIDX_W-1:0] kept_index;
    logic end_of_run;

    polyline_douglas_peucker dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .pos_x(pos_x),
        .pos_y(pos_y), .is_last(is_last), .result_strobe(result_strobe),
        .kept_x(kept_x), .kept_y(kept_y), .kept_index(kept_index),
        .end_of_run(end_of_run)
    );

    always #5 clk = ~clk;

    // Pending points for the driver, and the kept points still to arrive.
    point_t pending_pts[$];
    kept_t  kept_due[$];
    int     fail_count = 0;
    int     items_made = 0;
    int     idle_cycles = 0;
    bit     gaps_on = 1'b1;

    // The testbench's own copy of the block's configuration and point store.
    logic [TOL_W-1:0]     tol_now = TOL_RESET;
    logic [SPACING_W-1:0] spacing_now = '0;
    longint               store_x[NPTS];
    longint               store_y[NPTS];
    bit                   keep_mark[NPTS];
    int                   stored = 0;

    // Examines one range: finds the inner point farthest from the chord,
    // the first one winning a tie, and returns it if it lies beyond tolerance.
    function automatic int farthest_beyond(int lo, int hi);
        longint ax, ay, abx, aby, nsq, dx, dy, m;
        longint unsigned worst, metric, tsq;
        bit [127:0] wide_w, wide_t;
        int worst_k;
        begin
            ax = store_x[lo];
            ay = store_y[lo];
            abx = store_x[hi] - ax;
            aby = store_y[hi] - ay;
            nsq = abx * abx + aby * aby;
            tsq = longint'(tol_now) * longint'(tol_now);
            worst = 0;
            worst_k = lo + 1;
            for (int k = lo + 1; k < hi; k++)
            begin
                dx = ax - store_x[k];
                dy = ay - store_y[k];
                if (nsq == 0)
                begin
                    metric = dx * dx + dy * dy;
                end
                else
                begin
                    m = abx * dy - dx * aby;
                    metric = (m < 0) ? -m : m;
                end
                if (k == lo + 1 || metric > worst)
                begin
                    worst = metric;
                    worst_k = k;
                end
            end
            if (nsq == 0)
            begin
                return (worst > tsq) ? worst_k : -1;
            end
            wide_w = 128'(worst) * 128'(worst);
            wide_t = 128'(tsq) * 128'(nsq);
            return (wide_w > wide_t) ? worst_k : -1;
        end
    endfunction

    // Simplifies the stored polyline and queues the kept points in order.
    task automatic simplify_stored();
        int lo_stk[$];
        int hi_stk[$];
        int lo;
        int hi;
        int k;
        kept_t r;
        begin
            for (int i = 0; i < NPTS; i++)
                keep_mark[i] = 1'b0;
            if (stored < 3 || tol_now == 0)
            begin
                for (int i = 0; i < stored; i++)
                    keep_mark[i] = 1'b1;
            end
            else
            begin
                keep_mark[0] = 1'b1;
                keep_mark[stored-1] = 1'b1;
                lo_stk.push_back(0);
                hi_stk.push_back(stored - 1);
                while (lo_stk.size() > 0)
                begin
                    lo = lo_stk.pop_back();
                    hi = hi_stk.pop_back();
                    if (hi > lo + 1)
                    begin
                        k = farthest_beyond(lo, hi);
                        if (k >= 0)
                        begin
                            keep_mark[k] = 1'b1;
                            lo_stk.push_back(lo);
                            hi_stk.push_back(k);
                            lo_stk.push_back(k);
                            hi_stk.push_back(hi);
                        end
                    end
                end
                if (spacing_now > 0)
                begin
                    for (int i = 0; i < stored; i += spacing_now)
                        keep_mark[i] = 1'b1;
                    keep_mark[stored-1] = 1'b1;
                end
            end
            for (int i = 0; i < stored; i++)
            begin
                if (keep_mark[i])
                begin
                    r.x = store_x[i][CB-1:0];
                    r.y = store_y[i][CB-1:0];
                    r.idx = i[KIDX_W-1:0];
                    r.eor = (i == stored - 1);
                    kept_due.push_back(r);
                end
            end
            stored = 0;
        end
    endtask

    // Stores one accepted point; the final point of a polyline triggers the run.
    task automatic take_point(point_t p);
        begin
            if (stored < NPTS)
            begin
                store_x[stored] = p.x;
                store_y[stored] = p.y;
                stored++;
            end
            if (p.last)
                simplify_stored();
        end
    endtask

    // Driver: a transaction completes when start is high and busy low.
    // start is assigned once per edge, so a back-to-back item keeps it high.
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        bit     free;
        int     roll;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            free = !start || !busy;
            if (start && !busy)
                take_point('{x: pos_x, y: pos_y, last: is_last});
            if (free)
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_pts.size() > 0)
                begin
                    p = pending_pts.pop_front();
                    pos_x <= p.x;
                    pos_y <= p.y;
                    is_last <= p.last;
                    start <= 1'b1;
                    roll = $urandom_range(0, 99);
                    if (!gaps_on || roll < 65)
                        gap_left <= 0;
                    else if (roll < 95)
                        gap_left <= $urandom_range(1, 3);
                    else
                        gap_left <= $urandom_range(10, 40);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is checked against the oldest kept point due.
    always @(posedge clk)
    begin
        kept_t e;
        if (rst_n && result_strobe)
        begin
            if (kept_due.size() == 0)
            begin
                $error("unexpected result: kept_index %0d", kept_index);
                fail_count++;
            end
            else
            begin
                e = kept_due.pop_front();
                if (kept_x !== e.x)
                begin
                    $error("kept_x: expected %0d, actual %0d", e.x, kept_x);
                    fail_count++;
                end
                if (kept_y !== e.y)
                begin
                    $error("kept_y: expected %0d, actual %0d", e.y, kept_y);
                    fail_count++;
                end
                if (kept_index !== e.idx)
                begin
                    $error("kept_index: expected %0d, actual %0d", e.idx, kept_index);
                    fail_count++;
                end
                if (end_of_run !== e.eor)
                begin
                    $error("end_of_run: expected %0d, actual %0d", e.eor, end_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic add_point(longint x, longint y, bit last);
        begin
            pending_pts.push_back('{x: x[CB-1:0], y: y[CB-1:0], last: last});
            items_made++;
        end
    endtask

    function automatic longint clamp_coord(longint v);
        begin
            if (v > 8388607)
                return 8388607;
            if (v < -8388608)
                return -8388608;
            return v;
        end
    endfunction

    // A polyline of n points in one of several shapes. Most are random walks
    // whose bends sit near the tolerance, so both outcomes of a split occur.
    task automatic add_polyline(int n, int shape);
        longint x, y, x0, y0, stepsz;
        begin
            x = $signed($urandom_range(0, 2000)) - 1000;
            y = $signed($urandom_range(0, 2000)) - 1000;
            x0 = x;
            y0 = y;
            stepsz = $urandom_range(1, 4) * 256;
            for (int i = 0; i < n; i++)
            begin
                case (shape)
                    0:
                    begin
                        x = clamp_coord(x + $signed($urandom_range(0, 2 * stepsz)) - stepsz);
                        y = clamp_coord(y + $signed($urandom_range(0, 2 * stepsz)) - stepsz);
                    end
                    1:
                    begin
                        x = $signed({{40{1'b0}}, $urandom()} & 64'hFFFFFF);
                        y = $signed({{40{1'b0}}, $urandom()} & 64'hFFFFFF);
                        x = (x >= 8388608) ? x - 16777216 : x;
                        y = (y >= 8388608) ? y - 16777216 : y;
                    end
                    2:
                    begin
                        x = x0 + i * 100;
                        y = y0 + i * 37;
                    end
                    default:
                    begin
                        // Closed loop: the chord of the whole line collapses.
                        if (i == n - 1)
                        begin
                            x = x0;
                            y = y0;
                        end
                        else if (i > 0)
                        begin
                            x = clamp_coord(x + $signed($urandom_range(0, 2 * stepsz)) - stepsz);
                            y = clamp_coord(y + $signed($urandom_range(0, 2 * stepsz)) - stepsz);
                        end
                    end
                endcase
                add_point(x, y, i == n - 1);
            end
        end
    endtask

    // Lets the queued points drain and the run finish, so the block is idle.
    task automatic settle();
        begin
            while (pending_pts.size() > 0)
                @(posedge clk);
            @(posedge clk);
            while (start || busy || kept_due.size() > 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t which, int unsigned value);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= which;
            cfg_data <= value[CFG_DATA_W-1:0];
            @(posedge clk);
            cfg_we <= 1'b0;
            if (which == REG_TOLERANCE)
                tol_now = value[TOL_W-1:0];
            else
                spacing_now = value[SPACING_W-1:0];
        end
    endtask

    task automatic set_config(int unsigned tol, int unsigned spacing);
        begin
            settle();
            write_reg(REG_TOLERANCE, tol);
            write_reg(REG_MAX_SPACING, spacing);
        end
    endtask

    initial
    begin
        int unsigned tol_pick;
        int unsigned sp_pick;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration: extreme coordinates,
        // a lone point, two points, a straight line and a closed loop.
        add_point(-8388608, 8388607, 1'b0);
        add_point(8388607, -8388608, 1'b0);
        add_point(0, 0, 1'b1);
        add_point(-1, -1, 1'b1);
        add_point(5, 6, 1'b0);
        add_point(7, 8, 1'b1);
        add_polyline(5, 2);
        add_polyline(6, 3);

        // Zero tolerance keeps all points; the largest is then tried on random points.
        set_config(0, 0);
        add_polyline(4, 0);
        set_config(8388607, 64);
        add_polyline(5, 1);
        set_config(1, 1);
        add_polyline(4, 0);

        // An overlong polyline: points past the store are dropped.
        set_config(256, 0);
        gaps_on = 1'b0;
        add_polyline(70, 0);
        settle();
        gaps_on = 1'b1;

        while (items_made < 470)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: tol_pick = 0;
                    1: tol_pick = 8388607;
                    2: tol_pick = $urandom_range(1, 64);
                    default: tol_pick = $urandom_range(64, 1024);
                endcase
                case ($urandom_range(0, 4))
                    0: sp_pick = 0;
                    1: sp_pick = 64;
                    2: sp_pick = 1;
                    default: sp_pick = $urandom_range(2, 9);
                endcase
                gaps_on = $urandom_range(0, 3) != 0;
                set_config(tol_pick, sp_pick);
            end
            if ($urandom_range(0, 19) == 0)
                n = $urandom_range(40, 66);
            else
                n = $urandom_range(1, 14);
            add_polyline(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/pdp_pkg.sv
design/pdp_ram.sv
design/pdp_mul.sv
design/polyline_douglas_peucker.sv
design/pdp_checker.sv
tb/polyline_douglas_peucker_tb.sv
